>>> rtl/rpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and codes for the region permission table.
// ----------------------------------------------------------------------------
package rpt_pkg;
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 32;
    localparam int SIZE_W  = 33;
    localparam int TOT_W   = 47;
    localparam int PERM_W  = 3;

    localparam logic [1:0] OP_MAP     = 2'd0;
    localparam logic [1:0] OP_UNMAP   = 2'd1;
    localparam logic [1:0] OP_PROTECT = 2'd2;
    localparam logic [1:0] OP_CHECK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [PERM_W-1:0] perm;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic             fits_one_region;
        logic             span_allowed;
        logic [TOT_W-1:0] mapped_total;
    } t_rsp;
endpackage
`default_nettype wire

>>> rtl/rpt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface rpt_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rpt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_front
// Two-entry request queue between the input port and the table engine.
// ----------------------------------------------------------------------------
module rpt_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire rpt_pkg::t_req i_req,
    input  wire logic         i_valid,
    output logic              o_ready,
    output rpt_pkg::t_req     o_req,
    output logic              o_valid,
    input  wire logic         i_ready
);
    import rpt_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_req;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/rpt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_back
// Table engine: map/unmap/protect and single-region checks finish in idle;
// a span check walks region hops in the span state. Holds a result register.
// ----------------------------------------------------------------------------
module rpt_back #(
    parameter int REGION_COUNT = 16,
    parameter int PAGE_BYTES   = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rpt_pkg::t_req i_req,
    input  wire logic          i_valid,
    output logic               o_ready,
    output rpt_pkg::t_rsp      o_rsp,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import rpt_pkg::*;

    localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int PG_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int GRD_W = $clog2(REGION_COUNT + 2);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SPAN = 2'd1;

    logic [ADDR_W-1:0] r_base  [REGION_COUNT];
    logic [SIZE_W-1:0] r_size  [REGION_COUNT];
    logic [PERM_W-1:0] r_bits  [REGION_COUNT];
    logic [REGION_COUNT-1:0] r_valid;
    logic [TOT_W-1:0]  r_total;

    logic [1:0]        r_state;
    logic [ADDR_W:0]   r_cur;     // one extra bit: may run past the address space
    logic [LEN_W:0]    r_rem;
    logic [PERM_W-1:0] r_perm;
    logic [GRD_W-1:0]  r_guard;
    t_rsp              r_rsp;
    logic              r_ovalid;

    logic w_out_free;
    assign w_out_free = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;
    assign o_ready = (r_state == S_IDLE) && w_out_free;

    // region end addresses and containment of the lookup address
    logic [ADDR_W:0]         w_end [REGION_COUNT];
    logic [ADDR_W:0]         w_look;
    logic [REGION_COUNT-1:0] w_hit, w_bmatch;
    logic                    w_found, w_bfound;
    logic [IDX_W-1:0]        w_slot, w_bslot;

    assign w_look = (r_state == S_SPAN) ? r_cur : {1'b0, i_req.address};

    always_comb begin
        for (int i = 0; i < REGION_COUNT; i++) begin
            w_end[i]    = {1'b0, r_base[i]} + (ADDR_W+1)'(r_size[i]);
            w_hit[i]    = r_valid[i] && (w_look >= {1'b0, r_base[i]}) && (w_look < w_end[i]);
            w_bmatch[i] = r_valid[i] && (r_base[i] == i_req.address);
        end
        w_found = 1'b0; w_slot = '0; w_bfound = 1'b0; w_bslot = '0;
        for (int i = REGION_COUNT - 1; i >= 0; i--) begin
            if (w_hit[i])    begin w_found  = 1'b1; w_slot  = IDX_W'(i); end
            if (w_bmatch[i]) begin w_bfound = 1'b1; w_bslot = IDX_W'(i); end
        end
    end

    // page rounding of the map length
    logic [SIZE_W-1:0] w_round;
    always_comb begin
        logic [SIZE_W-1:0] t;
        t = {1'b0, i_req.length} + SIZE_W'(PAGE_BYTES - 1);
        w_round = (PAGE_BYTES > 1) ? ((t >> PG_W) << PG_W) : t;
    end

    // chunk for the current hop
    logic              w_perm_ok;
    logic [ADDR_W:0]   w_chunk;
    logic [LEN_W:0]    w_rem_src;
    logic [PERM_W-1:0] w_perm_src;
    assign w_rem_src  = (r_state == S_SPAN) ? r_rem : {1'b0, i_req.length};
    assign w_perm_src = (r_state == S_SPAN) ? r_perm : i_req.perm;
    assign w_perm_ok  = w_found && ((r_bits[w_slot] & w_perm_src) != '0);
    assign w_chunk    = w_end[w_slot] - w_look;

    logic             w_big;
    logic [LEN_W:0]   w_take;
    assign w_big  = w_chunk >= (ADDR_W+1)'(w_rem_src);
    assign w_take = w_big ? w_rem_src : w_chunk[LEN_W:0];

    logic w_fits_now;
    assign w_fits_now = w_perm_ok &&
        ({1'b0, i_req.address} + (ADDR_W+1)'(i_req.length) <= w_end[w_slot]);

    // table update and span sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_total  <= '0;
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_rsp.fits_one_region <= 1'b0;
                        r_rsp.span_allowed    <= 1'b0;
                        r_rsp.status          <= ST_OK;
                        r_rsp.mapped_total    <= r_total;
                        r_ovalid              <= 1'b1;
                        unique case (i_req.operation)
                            OP_MAP: begin
                                if (r_valid[REGION_COUNT-1]) begin
                                    r_rsp.status <= ST_FULL;
                                end else begin
                                    for (int i = REGION_COUNT - 1; i > 0; i--) begin
                                        r_base[i]  <= r_base[i-1];
                                        r_size[i]  <= r_size[i-1];
                                        r_bits[i]  <= r_bits[i-1];
                                        r_valid[i] <= r_valid[i-1];
                                    end
                                    r_base[0]  <= i_req.address;
                                    r_size[0]  <= w_round;
                                    r_bits[0]  <= i_req.perm;
                                    r_valid[0] <= 1'b1;
                                    r_total    <= r_total + TOT_W'(w_round);
                                    r_rsp.mapped_total <= r_total + TOT_W'(w_round);
                                end
                            end
                            OP_UNMAP: begin
                                if (!w_bfound) begin
                                    r_rsp.status <= ST_NOTFOUND;
                                end else begin
                                    for (int i = 0; i < REGION_COUNT - 1; i++) begin
                                        if (IDX_W'(i) >= w_bslot) begin
                                            r_base[i]  <= r_base[i+1];
                                            r_size[i]  <= r_size[i+1];
                                            r_bits[i]  <= r_bits[i+1];
                                            r_valid[i] <= r_valid[i+1];
                                        end
                                    end
                                    r_valid[REGION_COUNT-1] <= 1'b0;
                                    r_total <= r_total - TOT_W'(r_size[w_bslot]);
                                    r_rsp.mapped_total <= r_total - TOT_W'(r_size[w_bslot]);
                                end
                            end
                            OP_PROTECT: begin
                                if (!w_found) r_rsp.status <= ST_NOTFOUND;
                                else          r_bits[w_slot] <= i_req.perm;
                            end
                            default: begin
                                // check: first hop in this cycle
                                r_rsp.fits_one_region <= w_fits_now;
                                r_perm <= i_req.perm;
                                if (i_req.length == '0) begin
                                    r_rsp.span_allowed <= 1'b1;
                                end else if (!w_perm_ok) begin
                                    r_rsp.span_allowed <= 1'b0;
                                end else if (w_big) begin
                                    r_rsp.span_allowed <= 1'b1;
                                end else begin
                                    r_cur    <= w_look + w_chunk;
                                    r_rem    <= w_rem_src - w_take;
                                    r_guard  <= GRD_W'(1);
                                    r_ovalid <= 1'b0;
                                    r_state  <= S_SPAN;
                                end
                            end
                        endcase
                    end
                end
                S_SPAN: begin
                    if (!w_perm_ok || w_big || r_guard == GRD_W'(REGION_COUNT)) begin
                        if (w_out_free) begin
                            r_rsp.span_allowed <= w_perm_ok && w_big;
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_cur   <= w_look + w_chunk;
                        r_rem   <= w_rem_src - w_take;
                        r_guard <= r_guard + GRD_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/region_permission_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// region_permission_table_core
// Guest region permission table: map, unmap, protect and access check.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed by the table engine.
// Map, unmap, protect and single-region checks finish in the engine's
// idle state; a check whose span crosses regions walks each extra region
// (at most REGION_COUNT) in the span state via the single shared region
// lookup. One result per request, held in an output register.
module region_permission_table_core #(
    parameter int REGION_COUNT = 16,
    parameter int PAGE_BYTES   = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rpt_if.sink       i_req,
    rpt_if.source     o_rsp
);
    import rpt_pkg::*;

    t_req w_req;
    logic w_valid, w_ready;

    rpt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(i_req.data), .i_valid(i_req.valid), .o_ready(i_req.ready),
        .o_req(w_req), .o_valid(w_valid), .i_ready(w_ready)
    );

    rpt_back #(.REGION_COUNT(REGION_COUNT), .PAGE_BYTES(PAGE_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(w_req), .i_valid(w_valid), .o_ready(w_ready),
        .o_rsp(o_rsp.data), .o_valid(o_rsp.valid), .i_ready(o_rsp.ready)
    );

    // failed operations report neither fit nor span
    a_nocheck_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.status != ST_OK |->
            !o_rsp.data.fits_one_region && !o_rsp.data.span_allowed)
        else $error("flags set on failed op");
    // status code is never out of range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.data.status != 2'd3)
        else $error("bad status");
    // a single-region fit implies the span is covered
    a_fit_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.fits_one_region |-> o_rsp.data.span_allowed)
        else $error("fit without span");
endmodule
`default_nettype wire

>>> verif/region_table_checker.sv
// ----------------------------------------------------------------------------
// region_table_checker
// Watches the request and response channels of the region permission table,
// keeps its own copy of the region list and compares every response.
// ----------------------------------------------------------------------------
module region_table_checker #(
    parameter int REGION_COUNT = 16,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  rpt_pkg::t_req i_req_data,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  rpt_pkg::t_rsp i_rsp_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_rsp_count,
    output int            o_check_count,
    output int            o_full_count,
    output int            o_region_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rpt_pkg::*;

    // Shadow region list, slot 0 newest
    logic [ADDR_W-1:0] reg_base [REGION_COUNT];
    logic [SIZE_W-1:0] reg_size [REGION_COUNT];
    logic [PERM_W-1:0] reg_bits [REGION_COUNT];
    logic              reg_live [REGION_COUNT];
    logic [TOT_W-1:0]  byte_total;
    t_rsp              expected_rsps[$];

    // Newest live slot holding address a, -1 if none
    function automatic int owner_slot(logic [63:0] a);
        for (int i = 0; i < REGION_COUNT; i++) begin
            if (!reg_live[i]) return -1;
            if (a >= 64'(reg_base[i]) && a < 64'(reg_base[i]) + 64'(reg_size[i])) return i;
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return the response it gives
    function automatic t_rsp apply_request(t_req rq);
        t_rsp        r;
        int          s;
        logic [63:0] a, len, sz, cur, rem, chunk;
        logic        ok;
        r = '0;
        a = 64'(rq.address);
        len = 64'(rq.length);
        case (rq.operation)
            OP_MAP: begin
                if (reg_live[REGION_COUNT-1]) begin
                    r.status = ST_FULL;
                end else begin
                    sz = ((len + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
                    for (int i = REGION_COUNT - 1; i > 0; i--) begin
                        reg_base[i] = reg_base[i-1];
                        reg_size[i] = reg_size[i-1];
                        reg_bits[i] = reg_bits[i-1];
                        reg_live[i] = reg_live[i-1];
                    end
                    reg_base[0] = rq.address;
                    reg_size[0] = SIZE_W'(sz);
                    reg_bits[0] = rq.perm;
                    reg_live[0] = 1'b1;
                    byte_total = byte_total + TOT_W'(sz);
                end
            end
            OP_UNMAP: begin
                s = -1;
                for (int i = 0; i < REGION_COUNT; i++) begin
                    if (!reg_live[i]) break;
                    if (reg_base[i] == rq.address) begin
                        s = i;
                        break;
                    end
                end
                if (s < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    byte_total = byte_total - TOT_W'(reg_size[s]);
                    for (int i = s; i < REGION_COUNT - 1; i++) begin
                        reg_base[i] = reg_base[i+1];
                        reg_size[i] = reg_size[i+1];
                        reg_bits[i] = reg_bits[i+1];
                        reg_live[i] = reg_live[i+1];
                    end
                    reg_live[REGION_COUNT-1] = 1'b0;
                end
            end
            OP_PROTECT: begin
                s = owner_slot(a);
                if (s < 0) r.status = ST_NOTFOUND;
                else reg_bits[s] = rq.perm;
            end
            default: begin
                // Single region fit
                s = owner_slot(a);
                r.fits_one_region = (s >= 0) &&
                    (a + len <= 64'(reg_base[s]) + 64'(reg_size[s])) &&
                    ((reg_bits[s] & rq.perm) != 0);
                // Walk chained regions across the span
                cur = a;
                rem = len;
                ok = 1'b1;
                for (int g = 0; g <= REGION_COUNT && rem != 0 && ok; g++) begin
                    s = owner_slot(cur);
                    if (s < 0 || (reg_bits[s] & rq.perm) == 0) begin
                        ok = 1'b0;
                    end else begin
                        chunk = 64'(reg_base[s]) + 64'(reg_size[s]) - cur;
                        if (chunk > rem) chunk = rem;
                        cur += chunk;
                        rem -= chunk;
                    end
                end
                r.span_allowed = ok && rem == 0;
            end
        endcase
        r.mapped_total = byte_total;
        return r;
    endfunction

    always_comb begin
        o_region_count = 0;
        for (int i = 0; i < REGION_COUNT; i++) o_region_count += int'(reg_live[i]);
    end

    // Predict on request transfers, compare on response transfers
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < REGION_COUNT; i++) reg_live[i] = 1'b0;
            byte_total = '0;
            expected_rsps.delete();
            o_fail_count <= 0;
            o_pending <= 0;
            o_rsp_count <= 0;
            o_check_count <= 0;
            o_full_count <= 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("response transfer with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want !== i_rsp_data) o_fail_count <= o_fail_count + 1;
                    if (want.status !== i_rsp_data.status)
                        $error("status: expected %0d, got %0d", want.status,
                               i_rsp_data.status);
                    if (want.fits_one_region !== i_rsp_data.fits_one_region)
                        $error("fits_one_region: expected %0d, got %0d",
                               want.fits_one_region, i_rsp_data.fits_one_region);
                    if (want.span_allowed !== i_rsp_data.span_allowed)
                        $error("span_allowed: expected %0d, got %0d",
                               want.span_allowed, i_rsp_data.span_allowed);
                    if (want.mapped_total !== i_rsp_data.mapped_total)
                        $error("mapped_total: expected %0h, got %0h",
                               want.mapped_total, i_rsp_data.mapped_total);
                end
                o_rsp_count <= o_rsp_count + 1;
            end
            if (i_req_valid && i_req_ready) begin
                want = apply_request(i_req_data);
                expected_rsps.push_back(want);
                if (i_req_data.operation == OP_CHECK && want.span_allowed)
                    o_check_count <= o_check_count + 1;
                if (want.status == ST_FULL) o_full_count <= o_full_count + 1;
            end
            o_pending <= expected_rsps.size();
        end
    end
endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives map, unmap, protect and check requests into the region table under
// several idle and stall mixes; the checker judges every response.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rpt_pkg::*;

    localparam int REGIONS = 16;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, rsp_count, span_ok_count, full_count, live_regions;
    int   send_idle_pct, recv_stall_pct;
    logic [ADDR_W-1:0] used_bases[$];

    rpt_if #(.T(t_req)) req_ch ();
    rpt_if #(.T(t_rsp)) rsp_ch ();

    region_permission_table_core #(.REGION_COUNT(REGIONS), .PAGE_BYTES(4096)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    region_table_checker #(.REGION_COUNT(REGIONS), .PAGE_BYTES(4096)) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_ch.valid),
        .i_req_ready    (req_ch.ready),
        .i_req_data     (req_ch.data),
        .i_rsp_valid    (rsp_ch.valid),
        .i_rsp_ready    (rsp_ch.ready),
        .i_rsp_data     (rsp_ch.data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_rsp_count    (rsp_count),
        .o_check_count  (span_ok_count),
        .o_full_count   (full_count),
        .o_region_count (live_regions)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: random stalls at the falling edge
    always @(negedge i_clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Present one request and hold it until the transfer; valid stays high
    // on return, the next request or an idle drop takes it down
    task automatic send_req(logic [1:0] op, logic [ADDR_W-1:0] a,
                            logic [LEN_W-1:0] len, logic [PERM_W-1:0] p);
        t_req rq;
        rq.operation = op;
        rq.address = a;
        rq.length = len;
        rq.perm = p;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= rq;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if (op == OP_MAP) used_bases.push_back(a);
    endtask

    // Address near a known base, or anywhere
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] b;
        if (used_bases.size() == 0 || $urandom_range(9) == 0)
            return ADDR_W'({$urandom(), $urandom()});
        b = used_bases[$urandom_range(used_bases.size() - 1)];
        case ($urandom_range(3))
            0: return b;
            1: return b + ADDR_W'($urandom_range(20000));
            2: return b - ADDR_W'($urandom_range(64));
            default: return b + ADDR_W'(4096 * $urandom_range(4)) - ADDR_W'($urandom_range(1));
        endcase
    endfunction

    task automatic random_req();
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] base;
        int k;
        k = $urandom_range(99);
        case ($urandom_range(3))
            0: len = $urandom_range(3);
            1: len = $urandom_range(20000);
            2: len = $urandom();
            default: len = 4096 * $urandom_range(3);
        endcase
        if (k < 30 && live_regions < REGIONS - 2) begin
            // Keep regions clustered so spans chain across neighbors
            if (used_bases.size() > 0 && $urandom_range(1))
                base = used_bases[$urandom_range(used_bases.size() - 1)]
                       + ADDR_W'(4096 * $urandom_range(3));
            else
                base = ADDR_W'({$urandom(), $urandom()}) & 48'hFFFF_FFFF_F000;
            send_req(OP_MAP, base,
                     ($urandom_range(3) == 0) ? len : 32'($urandom_range(12000)),
                     PERM_W'($urandom_range(7)));
        end else if (k < 33) begin
            send_req(OP_MAP, pick_addr(), len, PERM_W'($urandom_range(7)));
        end else if (k < 48) begin
            send_req(OP_UNMAP, pick_addr(), len, PERM_W'($urandom_range(7)));
        end else if (k < 60) begin
            send_req(OP_PROTECT, pick_addr(), len, PERM_W'($urandom_range(7)));
        end else begin
            send_req(OP_CHECK, pick_addr(), len, PERM_W'($urandom_range(7)));
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: base zero, zero length, misses, extremes, full table
        send_req(OP_UNMAP, 48'h0, 32'h0, 3'd0);
        send_req(OP_PROTECT, 48'h1000, 32'h0, 3'd7);
        send_req(OP_CHECK, 48'h0, 32'h0, 3'd0);
        send_req(OP_MAP, 48'h0, 32'h1, 3'd1);
        send_req(OP_MAP, 48'h1000, 32'h0, 3'd7);
        send_req(OP_MAP, 48'h1000, 32'h2000, 3'd2);
        send_req(OP_CHECK, 48'h0, 32'h3000, 3'd2);
        send_req(OP_CHECK, 48'h0, 32'h3000, 3'd3);
        send_req(OP_CHECK, 48'hFFF, 32'h2, 3'd1);
        send_req(OP_CHECK, 48'h500, 32'h0, 3'd0);
        send_req(OP_CHECK, 48'h2000, 32'h0, 3'd4);
        send_req(OP_PROTECT, 48'h1800, 32'hFFFF_FFFF, 3'd4);
        send_req(OP_UNMAP, 48'h1000, 32'h0, 3'd0);
        send_req(OP_MAP, 48'hFFFF_FFFF_F000, 32'hFFFF_FFFF, 3'd7);
        send_req(OP_CHECK, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        for (int i = 0; i < 14; i++)
            send_req(OP_MAP, 48'h8000_0000 + 48'(i) * 48'h1000, 32'hFFF, 3'(i));
        send_req(OP_MAP, 48'h5555_5555_5555, 32'h1, 3'd7);
        send_req(OP_CHECK, 48'h8000_0000, 32'hE000, 3'd1);
        for (int i = 0; i < 16; i++) send_req(OP_UNMAP, used_bases[i], 32'h0, 3'd0);
        wait_drained();

        // Random phases with different idle mixes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 250; n++) begin
                random_req();
                if (n == 125) wait_drained();
            end
            if (used_bases.size() > 64) used_bases = used_bases[$-32:$];
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        $display("Covered %0d responses: %0d spans allowed, %0d table-full maps.",
                 rsp_count, span_ok_count, full_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> files.f
rtl/rpt_pkg.sv
rtl/rpt_if.sv
rtl/rpt_front.sv
rtl/rpt_back.sv
rtl/region_permission_table_core.sv
verif/region_table_checker.sv
verif/testbench.sv
